@@ design/assert_macros.svh @@
// Assertion macros shared by the stack engine RTL.
// Each macro clocks on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the antecedent.
`define LSE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Condition holds in the cycle after the antecedent.
`define LSE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lse_pkg.sv @@
// Package for the LIFO stack engine: sizes, opcodes, status codes,
// the memory request struct and word conversion functions. No dependencies.
package lse_pkg;

	localparam int DEPTH      = 128;
	localparam int WORD_WIDTH = 32;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_PEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [WORD_WIDTH-1:0] wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} mem_req_t;

	// Sign-extend the 32-bit request word, then keep the stored width.
	function automatic logic [WORD_WIDTH-1:0] to_word(input logic signed [31:0] v);
		logic signed [63:0] ext;
		ext = 64'(v);
		return ext[WORD_WIDTH-1:0];
	endfunction

	// Sign-extend a stored word, then cut it to the 32-bit result word.
	function automatic logic [31:0] widen_word(input logic [WORD_WIDTH-1:0] w);
		logic signed [WORD_WIDTH-1:0] s;
		logic signed [63:0]           ext;
		s   = w;
		ext = 64'(s);
		return ext[31:0];
	endfunction

endpackage

@@ design/lse_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No package dependencies.
module lse_ram #(
	parameter int DEPTH_P = 2,
	parameter int WIDTH_P = 1,
	localparam int AW = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [WIDTH_P-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [WIDTH_P-1:0] rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];
	logic [WIDTH_P-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/lse_ctrl.sv @@
// Stack control: fill level, request decode, memory request and result stage.
// Depends on lse_pkg.
module lse_ctrl import lse_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            opcode,
	input  logic signed [31:0]    push_value,
	output mem_req_t              mem_req,
	input  logic [WORD_WIDTH-1:0] mem_rdata,
	output logic                  done,
	output logic signed [31:0]    read_word,
	output logic [1:0]            status,
	output logic [7:0]            entry_count,
	output logic                  is_empty,
	output logic                  is_full
);

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_d;
	status_t          status_d;
	logic             use_mem_d;

	logic             valid_s1;
	status_t          status_s1;
	logic             use_mem_s1;
	logic [CNT_W-1:0] fill_s1;

	always_comb begin
		fill_d        = fill_q;
		status_d      = ST_OK;
		use_mem_d     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.waddr = fill_q[ADDR_W-1:0];
		mem_req.wdata = to_word(push_value);
		mem_req.raddr = ADDR_W'(fill_q - CNT_W'(1));
		case (op_t'(opcode))
			OP_PUSH: begin
				if (fill_q == CNT_W'(DEPTH)) begin
					status_d = ST_OVERFLOW;
				end else begin
					mem_req.we = accept;
					fill_d     = fill_q + CNT_W'(1);
				end
			end
			OP_POP, OP_PEEK: begin
				if (fill_q == '0) begin
					status_d = ST_UNDERFLOW;
				end else begin
					mem_req.re = accept;
					use_mem_d  = 1'b1;
					if (op_t'(opcode) == OP_POP) begin
						fill_d = fill_q - CNT_W'(1);
					end
				end
			end
			OP_CLEAR: begin
				fill_d = '0;
			end
			default: begin
				fill_d = fill_q;
			end
		endcase
	end

	// A push writes at one edge and a later pop reads at a later edge, so the
	// array already holds the word: no forwarding path is needed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				fill_q <= fill_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status_d;
			use_mem_s1 <= use_mem_d;
			fill_s1    <= fill_d;
		end
	end

	always_comb begin
		if (use_mem_s1) begin
			read_word = widen_word(mem_rdata);
		end else if (status_s1 == ST_UNDERFLOW) begin
			read_word = '1;
		end else begin
			read_word = '0;
		end
	end

	assign done        = valid_s1;
	assign status      = status_s1;
	assign entry_count = 8'(fill_s1);
	assign is_empty    = (fill_s1 == '0);
	assign is_full     = (fill_s1 == CNT_W'(DEPTH));

endmodule

@@ design/lifo_stack_engine_core.sv @@
// Top level of the LIFO stack engine: control stage plus the stack memory.
// Depends on lse_pkg, lse_ctrl, lse_ram and assert_macros.svh.
//
// Usage:
//   A request beat is taken at a rising edge where start is high and busy is
//   low. opcode selects push, pop, peek or clear; push_value is used by push.
//   busy stays low: the block takes one request every clock cycle.
//   Each request gives one result beat, marked by done, in the cycle after
//   the request edge. The result ports hold read_word, status,
//   entry_count, is_empty and is_full for that single cycle only; the
//   receiver must take it then, since it cannot hold results off.
//   The result is registered in the read port of the stack memory and in the
//   result stage of lse_ctrl; throughput is one request per cycle, as each
//   request touches one memory entry and moves the fill level by at most one.
//   Reset (arst_n low) empties the stack at once. The memory itself is not
//   cleared; only entries below the fill level are ever read, and each of
//   those was written by a push.
`include "assert_macros.svh"

module lifo_stack_engine_core import lse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] push_value,
	output logic               done,
	output logic signed [31:0] read_word,
	output logic [1:0]         status,
	output logic [7:0]         entry_count,
	output logic               is_empty,
	output logic               is_full
);

	mem_req_t              mem_req;
	logic [WORD_WIDTH-1:0] mem_rdata;
	logic                  accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	lse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode),
		.push_value (push_value),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata),
		.done       (done),
		.read_word  (read_word),
		.status     (status),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	lse_ram #(
		.DEPTH_P(DEPTH),
		.WIDTH_P(WORD_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.raddr),
		.rdata(mem_rdata)
	);

	`LSE_ASSERT_NXT(a_beat_gives_result, start && !busy, done, "request beat gave no result")
	`LSE_ASSERT_IMP(a_overflow_full, done && status == ST_OVERFLOW, is_full, "overflow while not full")
	`LSE_ASSERT_IMP(a_underflow_word, done && status == ST_UNDERFLOW, is_empty && read_word == -32'sd1, "bad underflow result")
	`LSE_ASSERT_IMP(a_empty_count, done && is_empty, entry_count == 8'd0, "empty flag with non-zero count")

endmodule
